### hw/rtl/arp_pkg.sv
package arp_pkg;

    // Input modes
    localparam logic [2:0] MODE_PACKET     = 3'd0;
    localparam logic [2:0] MODE_ADD        = 3'd1;
    localparam logic [2:0] MODE_SET        = 3'd2;
    localparam logic [2:0] MODE_LOOKUP_IP  = 3'd3;
    localparam logic [2:0] MODE_LOOKUP_MAC = 3'd4;
    localparam logic [2:0] MODE_TICK       = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_FRAME  = 2'd2;

    // ARP opcodes
    localparam logic [1:0]  TX_OP_REQUEST = 2'd1;
    localparam logic [1:0]  TX_OP_REPLY   = 2'd2;
    localparam logic [15:0] RX_OP_REQUEST = 16'd1;

    // Header checks
    localparam logic [15:0] HW_TYPE_ETH  = 16'h0001;
    localparam logic [15:0] PROTO_IPV4   = 16'h0800;
    localparam logic [7:0]  HW_LEN_ETH   = 8'd6;
    localparam logic [7:0]  PROTO_LEN_V4 = 8'd4;

    localparam logic [47:0] MAC_ZERO  = 48'h0000_0000_0000;
    localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] IP_ZERO   = 32'h0000_0000;
    localparam logic [31:0] IP_BCAST  = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam logic [7:0] REG_OWN_IP   = 8'd0;
    localparam logic [7:0] REG_OWN_MAC  = 8'd1;
    localparam logic [7:0] REG_AGING    = 8'd2;
    localparam logic [7:0] REG_ASK      = 8'd3;

    localparam logic [15:0] AGING_RESET = 16'd60;
    localparam logic [15:0] ASK_RESET   = 16'd10;

    localparam int IN_DATA_W  = 208;
    localparam int OUT_DATA_W = 216;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LEARN,
        ST_REPLY,
        ST_STATUS,
        ST_TICK_MAC,
        ST_TICK_IP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic learn;
        logic emit_reply;
        logic emit_status;
        logic tick_mac_step;
        logic tick_ip_step;
        logic clr_idx;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] mode;
        logic       hdr_ok;
        logic       reply_due;
        logic       ask_due;
        logic       idx_last;
        logic       out_free;
    } stat_t;

endpackage

### hw/rtl/arp_ctrl.sv
module arp_ctrl
    import arp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_tvalid,
    output logic   s_tready,
    input  stat_t  stat,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                case (stat.mode)
                    MODE_PACKET:     state_next = stat.hdr_ok ? ST_LEARN : ST_STATUS;
                    MODE_ADD,
                    MODE_SET:        state_next = ST_LEARN;
                    MODE_TICK: begin
                        cmd.clr_idx = 1'b1;
                        state_next  = ST_TICK_MAC;
                    end
                    default:         state_next = ST_STATUS;
                endcase
            end
            ST_LEARN: begin
                cmd.learn  = 1'b1;
                state_next = (stat.mode == MODE_PACKET && stat.reply_due) ? ST_REPLY
                                                                         : ST_STATUS;
            end
            ST_REPLY: begin
                if (stat.out_free) begin
                    cmd.emit_reply = 1'b1;
                    state_next     = ST_STATUS;
                end
            end
            ST_TICK_MAC: begin
                // a due re-ask needs the output register free
                if (!stat.ask_due || stat.out_free) begin
                    cmd.tick_mac_step = 1'b1;
                    if (stat.idx_last) begin
                        cmd.clr_idx = 1'b1;
                        state_next  = ST_TICK_IP;
                    end
                end
            end
            ST_TICK_IP: begin
                cmd.tick_ip_step = 1'b1;
                if (stat.idx_last) begin
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (stat.out_free) begin
                    cmd.emit_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### hw/rtl/arp_dp.sv
module arp_dp
    import arp_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [IN_DATA_W-1:0]    s_tdata,
    input  logic [2:0]              s_tuser,
    input  logic                    cfg_valid,
    input  logic [7:0]              cfg_index,
    input  logic [47:0]             cfg_data,
    output logic [OUT_DATA_W-1:0]   m_tdata,
    output logic [1:0]              m_tuser,
    output logic                    m_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  cmd_t                    cmd,
    output stat_t                   stat
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    // Configuration
    logic [31:0] own_ip_reg;
    logic [47:0] own_mac_reg;
    logic [15:0] aging_reg, ask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg  <= IP_ZERO;
            own_mac_reg <= MAC_ZERO;
            aging_reg   <= AGING_RESET;
            ask_reg     <= ASK_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_OWN_IP:  own_ip_reg  <= cfg_data[31:0];
                REG_OWN_MAC: own_mac_reg <= cfg_data;
                REG_AGING:   aging_reg   <= cfg_data[15:0];
                REG_ASK:     ask_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Captured item
    logic [2:0]  mode_reg;
    logic [31:0] now_reg, ip_reg, tgt_reg;
    logic [47:0] mac_reg;
    logic [15:0] hwt_reg, prt_reg, opc_reg;
    logic [7:0]  hwl_reg, prl_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= s_tuser;
            now_reg  <= s_tdata[31:0];
            mac_reg  <= s_tdata[79:32];
            ip_reg   <= s_tdata[111:80];
            tgt_reg  <= s_tdata[143:112];
            hwt_reg  <= s_tdata[159:144];
            prt_reg  <= s_tdata[175:160];
            hwl_reg  <= s_tdata[183:176];
            prl_reg  <= s_tdata[191:184];
            opc_reg  <= s_tdata[207:192];
        end
    end

    // Tables
    logic [TABLE_DEPTH-1:0] mac_valid_reg, ip_valid_reg;
    logic [47:0] mac_key_reg      [TABLE_DEPTH];
    logic [31:0] mac_entry_ip_reg [TABLE_DEPTH];
    logic [31:0] last_update_reg  [TABLE_DEPTH];
    logic [31:0] last_ask_reg     [TABLE_DEPTH];
    logic [31:0] ip_key_reg       [TABLE_DEPTH];
    logic [47:0] ip_entry_mac_reg [TABLE_DEPTH];

    // Walk index for ticks
    logic [IDX_W-1:0] idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.clr_idx) begin
            idx_reg <= '0;
        end else if (cmd.tick_mac_step || cmd.tick_ip_step) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Parallel key compare, lowest index wins
    logic [IDX_W-1:0] mac_idx, mac_free_idx, ip_idx, ip_free_idx;
    logic mac_hit, mac_free_ok, ip_hit, ip_free_ok;

    always_comb begin
        mac_idx = '0; mac_free_idx = '0; ip_idx = '0; ip_free_idx = '0;
        mac_hit = 1'b0; mac_free_ok = 1'b0; ip_hit = 1'b0; ip_free_ok = 1'b0;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
            if (mac_valid_reg[k] && mac_key_reg[k] == mac_reg) begin
                mac_hit = 1'b1; mac_idx = IDX_W'(k);
            end
            if (!mac_valid_reg[k]) begin
                mac_free_ok = 1'b1; mac_free_idx = IDX_W'(k);
            end
            if (ip_valid_reg[k] && ip_key_reg[k] == ip_reg) begin
                ip_hit = 1'b1; ip_idx = IDX_W'(k);
            end
            if (!ip_valid_reg[k]) begin
                ip_free_ok = 1'b1; ip_free_idx = IDX_W'(k);
            end
        end
    end

    logic [IDX_W-1:0] mac_idx_reg, mac_free_idx_reg, ip_idx_reg, ip_free_idx_reg;
    logic mac_hit_reg, mac_free_ok_reg, ip_hit_reg, ip_free_ok_reg;

    always_ff @(posedge aclk) begin
        mac_idx_reg      <= mac_idx;
        mac_free_idx_reg <= mac_free_idx;
        ip_idx_reg       <= ip_idx;
        ip_free_idx_reg  <= ip_free_idx;
        mac_hit_reg      <= mac_hit;
        mac_free_ok_reg  <= mac_free_ok;
        ip_hit_reg       <= ip_hit;
        ip_free_ok_reg   <= ip_free_ok;
    end

    // Learn decision
    logic key_bad, learn_ok, fresh;
    logic [IDX_W-1:0] wr_mi, wr_ii;

    always_comb begin
        key_bad  = (ip_reg == IP_ZERO) || (ip_reg == IP_BCAST) || (mac_reg == MAC_ZERO)
                || (mac_reg == MAC_BCAST) || (mac_reg == own_mac_reg);
        learn_ok = !key_bad && !(mode_reg == MODE_ADD && mac_hit_reg)
                && (mac_hit_reg || mac_free_ok_reg) && (ip_hit_reg || ip_free_ok_reg);
        fresh    = !mac_hit_reg;
        wr_mi    = mac_hit_reg ? mac_idx_reg : mac_free_idx_reg;
        wr_ii    = ip_hit_reg ? ip_idx_reg : ip_free_idx_reg;
    end

    logic ok_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ok_reg <= 1'b0;
        end else if (cmd.learn) begin
            ok_reg <= learn_ok;
        end
    end

    // Tick checks on the walked entry
    logic [31:0] lu, la, el_upd, el_ask;
    logic aged, ask_due, ip_mac_live;

    always_comb begin
        lu      = last_update_reg[idx_reg];
        la      = last_ask_reg[idx_reg];
        el_upd  = now_reg - lu;
        el_ask  = now_reg - la;
        aged    = mac_valid_reg[idx_reg] && (lu > now_reg || el_upd >= {16'd0, aging_reg});
        ask_due = mac_valid_reg[idx_reg] && !aged
               && (la > now_reg || el_ask >= {16'd0, ask_reg});
        ip_mac_live = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (mac_valid_reg[k] && mac_key_reg[k] == ip_entry_mac_reg[idx_reg]) begin
                ip_mac_live = 1'b1;
            end
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_valid_reg <= '0;
            ip_valid_reg  <= '0;
        end else begin
            if (cmd.learn && learn_ok) begin
                mac_valid_reg[wr_mi] <= 1'b1;
                ip_valid_reg[wr_ii]  <= 1'b1;
            end
            if (cmd.tick_mac_step && aged) begin
                mac_valid_reg[idx_reg] <= 1'b0;
            end
            if (cmd.tick_ip_step && ip_valid_reg[idx_reg] && !ip_mac_live) begin
                ip_valid_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // Table contents
    always_ff @(posedge aclk) begin
        if (cmd.learn && learn_ok) begin
            if (fresh) begin
                mac_key_reg[wr_mi]  <= mac_reg;
                last_ask_reg[wr_mi] <= (mode_reg == MODE_ADD) ? now_reg : 32'd0;
            end
            mac_entry_ip_reg[wr_mi] <= ip_reg;
            last_update_reg[wr_mi]  <= now_reg;
            ip_key_reg[wr_ii]       <= ip_reg;
            ip_entry_mac_reg[wr_ii] <= mac_reg;
        end
        if (cmd.tick_mac_step && ask_due) begin
            last_ask_reg[idx_reg] <= now_reg;
        end
    end

    // Result fields
    logic        r_ok;
    logic [1:0]  r_kind, r_op;
    logic [31:0] r_fip, r_tip;
    logic [47:0] r_fmac, r_dst, r_tmac;
    logic        r_last, load;

    always_comb begin
        r_kind = KIND_STATUS; r_ok = 1'b0; r_fip = '0; r_fmac = '0;
        r_op = '0; r_dst = '0; r_tmac = '0; r_tip = '0; r_last = 1'b0;
        load = cmd.emit_reply || cmd.emit_status || (cmd.tick_mac_step && ask_due);
        if (cmd.emit_reply) begin
            r_kind = KIND_FRAME; r_op = TX_OP_REPLY;
            r_dst  = mac_reg; r_tmac = mac_reg; r_tip = ip_reg;
        end else if (cmd.tick_mac_step) begin
            r_kind = KIND_FRAME; r_op = TX_OP_REQUEST;
            r_dst  = MAC_BCAST; r_tip = mac_entry_ip_reg[idx_reg];
        end else begin
            r_last = 1'b1;
            case (mode_reg)
                MODE_PACKET, MODE_ADD, MODE_SET: r_ok = ok_reg;
                MODE_LOOKUP_IP: begin
                    r_kind = KIND_LOOKUP; r_ok = ip_hit_reg;
                    r_fmac = ip_hit_reg ? ip_entry_mac_reg[ip_idx_reg] : MAC_ZERO;
                end
                MODE_LOOKUP_MAC: begin
                    r_kind = KIND_LOOKUP; r_ok = mac_hit_reg;
                    r_fip  = mac_hit_reg ? mac_entry_ip_reg[mac_idx_reg] : IP_ZERO;
                end
                MODE_TICK: r_ok = 1'b1;
                default:   r_ok = 1'b0;
            endcase
        end
    end

    // Output register
    logic                  m_valid_reg, m_last_reg;
    logic [1:0]            m_user_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_user_reg <= r_kind;
            m_last_reg <= r_last;
            m_data_reg <= {5'd0, r_tip, r_tmac, r_dst, r_op, r_fmac, r_fip, r_ok};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // Status to controller
    always_comb begin
        stat.mode      = mode_reg;
        stat.hdr_ok    = hwt_reg == HW_TYPE_ETH && hwl_reg == HW_LEN_ETH
                      && prl_reg == PROTO_LEN_V4 && prt_reg == PROTO_IPV4;
        stat.reply_due = opc_reg == RX_OP_REQUEST && tgt_reg == own_ip_reg;
        stat.ask_due   = ask_due;
        stat.idx_last  = idx_reg == IDX_LAST;
        stat.out_free  = !m_valid_reg || m_tready;
    end

endmodule

### hw/rtl/arp_cache_with_aging_unit.sv
// IPv4 ARP cache with aging. Each input transfer carries a mode in s_tuser (packet, add,
// set, lookup by IP, lookup by MAC, tick) and produces zero or more ARP frame results
// (kind 2) followed by one final status or lookup result with m_tlast set. For lookups,
// unused modes and packets with a bad header, the search state registers the parallel key
// compare across both tables and the status state then loads the result. Adds, sets and
// valid packets pass through a learn state between the two, which writes the tables. A
// packet that is answered also passes a reply state, with the reply frame ahead of the
// status. A tick walks the MAC table one entry per cycle and then the IP table one entry
// per cycle before its final status. Output stalls hold the block in the reply and status
// states and on each re-request frame of a tick, which halts the MAC table walk.
// One item is processed at a time; the next input transfer can follow in the cycle after
// the final result is loaded. The user must write configuration over the cfg channel only
// while the block is idle; the block itself does not enforce this.
module arp_cache_with_aging_unit
    import arp_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now, mac, ip, target_ip, hw_type, proto_type, hw_len, proto_len, opcode
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // ok, found_ip, found_mac, tx_opcode, tx_dest_mac, tx_target_mac, tx_target_ip
    output logic [OUT_DATA_W-1:0] m_tdata,
    // kind
    output logic [1:0]            m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_index,
    input  logic [47:0]           cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    arp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    arp_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // An accepted item keeps the input closed in the next cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // Frames are never the final result
    a_frame_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_FRAME |-> !m_tlast)
        else $error("frame marked last");

    // Re-requests go to broadcast
    a_req_bcast: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_FRAME && m_tdata[82:81] == TX_OP_REQUEST
        |-> m_tdata[130:83] == MAC_BCAST)
        else $error("request frame not broadcast");

endmodule
